// ----- src/poly_voice_allocator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the voice allocator top level
// Immediate-implication and next-cycle-implication forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define PVA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, constants and helper functions of the voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

	localparam int MAX_VOICES = 8;
	localparam int VOICE_W    = 3;
	localparam int LIM_W      = 4;
	localparam int NOTE_W     = 7;
	localparam int PITCH_W    = 8;
	localparam int VEL_W      = 12;
	localparam int CVEL_W     = 11;
	localparam int OCT_W      = 3;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CVEL_W-1:0] VEL_FULL = CVEL_W'(1024);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VOICE_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_SHIFT = 1'b1;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_VOICES);

	typedef logic [VOICE_W-1:0]    voice_idx_t;
	typedef logic [NOTE_W-1:0]     note_t;
	typedef logic [MAX_VOICES-1:0] voice_mask_t;

	// write command into the voice file
	typedef struct packed {
		logic       gate_we;
		logic       gate_val;
		logic       note_we;
		voice_idx_t idx;
		note_t      note;
	} vf_cmd_t;

	// result of the shared compare unit for one voice
	typedef struct packed {
		logic hit;
		logic stop;
		logic free;
	} cmp_res_t;

	// pitch offset for an octave shift, 8-bit wrap; -4 saturates to -3
	function automatic logic [PITCH_W-1:0] oct_offset(input logic signed [OCT_W-1:0] oct);
		logic [PITCH_W-1:0] off;
		case (oct)
			3'sd3:   off = 8'd36;
			3'sd2:   off = 8'd24;
			3'sd1:   off = 8'd12;
			3'sd0:   off = 8'd0;
			-3'sd1:  off = 8'd244;
			-3'sd2:  off = 8'd232;
			default: off = 8'd220;
		endcase
		return off;
	endfunction

	// effective voice limit: zero acts as one, above the maximum saturates
	function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] raw);
		logic [LIM_W-1:0] l;
		if (raw == '0)
			l = LIM_W'(1);
		else if (raw > LIM_W'(MAX_VOICES))
			l = LIM_W'(MAX_VOICES);
		else
			l = raw;
		return l;
	endfunction

endpackage

`default_nettype wire

// ----- src/pva_if.sv -----
// ----------------------------------------------------------------------------
// pva_if
// Valid/ready channels of the voice allocator: note events in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_in_if;
	import pva_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    func;
	note_t                   note;
	logic signed [VEL_W-1:0] velocity;

	modport source (output valid, func, note, velocity, input ready);
	modport sink   (input valid, func, note, velocity, output ready);
endinterface

interface pva_out_if;
	import pva_pkg::*;

	logic               valid;
	logic               ready;
	logic               started;
	voice_idx_t         started_voice;
	note_t              started_pitch;
	logic [CVEL_W-1:0]  started_velocity;
	logic [7:0]         stopped_mask;
	logic [7:0]         gates_now;

	modport source (output valid, started, started_voice, started_pitch, started_velocity,
		stopped_mask, gates_now, input ready);
	modport sink   (input valid, started, started_voice, started_pitch, started_velocity,
		stopped_mask, gates_now, output ready);
endinterface

`default_nettype wire

// ----- src/pva_voice_file.sv -----
// ----------------------------------------------------------------------------
// pva_voice_file
// Gate bits and held notes of every voice, one write command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_voice_file (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pva_pkg::vf_cmd_t cmd,
	input  wire pva_pkg::voice_idx_t rd_idx,
	output pva_pkg::note_t        rd_note,
	output pva_pkg::voice_mask_t  gates
);
	import pva_pkg::*;

	voice_mask_t gate_q;
	note_t       held_q [MAX_VOICES];

	// gate bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= '0;
		end else if (cmd.gate_we) begin
			gate_q[cmd.idx] <= cmd.gate_val;
		end
	end

	// held notes, cleared to note 0 by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VOICES; i++)
				held_q[i] <= '0;
		end else if (cmd.note_we) begin
			held_q[cmd.idx] <= cmd.note;
		end
	end

	assign rd_note = held_q[rd_idx];
	assign gates   = gate_q;

endmodule

`default_nettype wire

// ----- src/pva_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// pva_cmp_unit
// Shared per-voice compare: note match, sounding-voice stop, free voice.
// ----------------------------------------------------------------------------
`default_nettype none

module pva_cmp_unit (
	input  wire pva_pkg::note_t    held,
	input  wire pva_pkg::note_t    note,
	input  wire logic              gate,
	output pva_pkg::cmp_res_t      res
);
	import pva_pkg::*;

	always_comb begin
		res.hit  = (held == note);
		res.stop = (held == note) && gate;
		res.free = !gate;
	end

endmodule

`default_nettype wire

// ----- src/poly_voice_allocator_top.sv -----
// ----------------------------------------------------------------------------
// poly_voice_allocator_top
// Polyphonic voice allocator with round-robin stealing: a sequencer scans
// the voices one per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     func, note, velocity
//  out_ch   out  valid/ready     started, started_voice, started_pitch,
//                                started_velocity, stopped_mask, gates_now
//  cfg      in   cfg_we          cfg_index, cfg_wdata
//
// An event passes through accept, one scan step for each active voice, a
// placement step for note-on (also taken by note-off), and result load.
// Reset clears all gates, held notes and the steal pointer at once.
// A new event is taken while the previous result waits; its result waits
// in the load step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_voice_allocator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pva_in_if.sink                             in_ch,
	pva_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pva_pkg::CFG_W-1:0]     cfg_wdata
);
	import pva_pkg::*;

`include "poly_voice_allocator_top_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_PLACE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [LIM_W-1:0]        cfg_lim_q;
	logic signed [OCT_W-1:0] cfg_oct_q;

	// per-event registers
	logic                    rel_q;
	note_t                   note_q;
	logic [CVEL_W-1:0]       vel_q;
	logic [PITCH_W-1:0]      off_q;
	logic [LIM_W-1:0]        lim_q;
	voice_idx_t              scan_q;
	voice_idx_t              chosen_q;
	logic                    found_q;
	voice_idx_t              ptr_q;
	voice_mask_t             stop_q;
	logic                    st_q;
	voice_idx_t              st_voice_q;
	note_t                   st_pitch_q;
	logic [CVEL_W-1:0]       st_vel_q;

	// output register
	logic                    out_vld_q;
	logic                    o_started_q;
	voice_idx_t              o_voice_q;
	note_t                   o_pitch_q;
	logic [CVEL_W-1:0]       o_vel_q;
	voice_mask_t             o_stop_q;
	voice_mask_t             o_gates_q;

	vf_cmd_t                 vf_cmd;
	note_t                   rd_note;
	voice_mask_t             gates;
	cmp_res_t                cmp;

	logic                    in_acc;
	logic [CVEL_W-1:0]       vel_clamp;
	logic                    scan_last;
	voice_idx_t              pick;
	logic [LIM_W-1:0]        pick_nxt;
	logic [PITCH_W-1:0]      pitch;
	logic                    out_load;

	pva_voice_file u_vf (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (vf_cmd),
		.rd_idx  (scan_q),
		.rd_note (rd_note),
		.gates   (gates)
	);

	pva_cmp_unit u_cmp (
		.held (rd_note),
		.note (note_q),
		.gate (gates[scan_q]),
		.res  (cmp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lim_q <= LIMIT_RESET;
			cfg_oct_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VOICE_LIMIT:  cfg_lim_q <= cfg_wdata;
				CFG_OCTAVE_SHIFT: cfg_oct_q <= OCT_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// handshake and velocity clamp
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_comb begin
		if (in_ch.velocity[VEL_W-1])
			vel_clamp = '0;
		else if (in_ch.velocity[CVEL_W-1:0] > VEL_FULL)
			vel_clamp = VEL_FULL;
		else
			vel_clamp = in_ch.velocity[CVEL_W-1:0];
	end

	// scan end, victim choice, shifted pitch
	assign scan_last = ((LIM_W'(scan_q) + LIM_W'(1)) == lim_q);

	always_comb begin
		if (found_q)
			pick = chosen_q;
		else if (LIM_W'(ptr_q) < lim_q)
			pick = ptr_q;
		else
			pick = '0;
	end

	assign pick_nxt = LIM_W'(pick) + LIM_W'(1);
	assign pitch    = PITCH_W'(note_q) + off_q;

	// voice file commands
	always_comb begin
		vf_cmd          = '0;
		vf_cmd.idx      = scan_q;
		vf_cmd.note     = note_q;
		if (state_q == ST_SCAN && rel_q && cmp.hit) begin
			vf_cmd.gate_we  = 1'b1;
			vf_cmd.gate_val = 1'b0;
		end else if (state_q == ST_PLACE && !rel_q) begin
			vf_cmd.idx      = pick;
			vf_cmd.gate_we  = 1'b1;
			vf_cmd.gate_val = !pitch[PITCH_W-1];
			vf_cmd.note_we  = 1'b1;
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last)
						state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (!rel_q && !found_q)
						ptr_q <= (pick_nxt == lim_q) ? '0 : VOICE_W'(pick_nxt);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-event datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rel_q      <= in_ch.func || (vel_clamp == '0);
				note_q     <= in_ch.note;
				vel_q      <= vel_clamp;
				off_q      <= oct_offset(cfg_oct_q);
				lim_q      <= eff_limit(cfg_lim_q);
				scan_q     <= '0;
				found_q    <= 1'b0;
				chosen_q   <= '0;
				stop_q     <= '0;
				st_q       <= 1'b0;
				st_voice_q <= '0;
				st_pitch_q <= '0;
				st_vel_q   <= '0;
			end
			ST_SCAN: begin
				if (rel_q) begin
					if (cmp.stop)
						stop_q <= stop_q | (MAX_VOICES'(1) << scan_q);
				end else if (cmp.free) begin
					chosen_q <= scan_q;
					found_q  <= 1'b1;
				end
				if (!scan_last)
					scan_q <= scan_q + VOICE_W'(1);
			end
			ST_PLACE: begin
				if (!rel_q) begin
					if (gates[pick])
						stop_q <= stop_q | (MAX_VOICES'(1) << pick);
					if (!pitch[PITCH_W-1]) begin
						st_q       <= 1'b1;
						st_voice_q <= pick;
						st_pitch_q <= pitch[NOTE_W-1:0];
						st_vel_q   <= vel_q;
					end
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_started_q <= st_q;
			o_voice_q   <= st_voice_q;
			o_pitch_q   <= st_pitch_q;
			o_vel_q     <= st_vel_q;
			o_stop_q    <= stop_q;
			o_gates_q   <= gates;
		end
	end

	assign out_ch.valid            = out_vld_q;
	assign out_ch.started          = o_started_q;
	assign out_ch.started_voice    = o_voice_q;
	assign out_ch.started_pitch    = o_pitch_q;
	assign out_ch.started_velocity = o_vel_q;
	assign out_ch.stopped_mask     = o_stop_q;
	assign out_ch.gates_now        = o_gates_q;

	// checks
	`PVA_ASSERT_NOW(a_started_gated, out_ch.valid && out_ch.started,
		out_ch.gates_now[out_ch.started_voice], "started voice not gated on")
	`PVA_ASSERT_NOW(a_stopped_silent, out_ch.valid,
		(out_ch.stopped_mask & out_ch.gates_now &
		~(out_ch.started ? (8'd1 << out_ch.started_voice) : 8'd0)) == 8'd0,
		"stopped voice still gated on")
	`PVA_ASSERT_NEXT(a_steal_ptr_range, state_q == ST_PLACE && !rel_q && !found_q,
		LIM_W'(ptr_q) < lim_q, "steal pointer beyond voice limit")
	`PVA_ASSERT_NEXT(a_accept_scan, in_acc, state_q == ST_SCAN,
		"accepted event did not start a scan")

endmodule

`default_nettype wire

// ----- verif/poly_voice_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// poly_voice_allocator_top_tb
// Self-checking bench for the voice allocator. A short directed table covers
// the clamp and steal corners. Random note traffic then runs under every
// voice limit and octave shift. An event-level predictor supplies the
// expected allocation for each accepted note event that has no typed result.
// Results are compared in order as they leave the block. Sender bursts and
// receiver stalls are random, and one long receiver hold backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_voice_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pva_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 40;
	localparam int RAND_PHASES   = 16;
	localparam int PHASE_EVENTS  = 100;
	localparam int HOLD_AFTER    = 600;
	localparam int HOLD_CYCLES   = 400;

	typedef enum logic {
		NOTE_ON  = 1'b0,
		NOTE_OFF = 1'b1
	} note_func_e;

	typedef enum logic {
		ROW_EVENT,
		ROW_CFG
	} row_kind_e;

	typedef struct packed {
		note_func_e              func;
		note_t                   note;
		logic signed [VEL_W-1:0] velocity;
	} note_event_t;

	typedef struct packed {
		logic              started;
		voice_idx_t        voice;
		note_t             pitch;
		logic [CVEL_W-1:0] velocity;
		voice_mask_t       stopped;
		voice_mask_t       gates;
	} alloc_result_t;

	typedef struct {
		row_kind_e              kind;
		note_event_t            ev;
		logic [CFG_IDX_W-1:0]   cfg_idx;
		logic [CFG_W-1:0]       cfg_val;
		bit                     typed;
		alloc_result_t          want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	pva_in_if  in_ch();
	pva_out_if out_ch();

	poly_voice_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state
	voice_mask_t          gate_state;
	logic [7:0]           held_notes [MAX_VOICES];
	int                   steal_ptr;
	logic [LIM_W-1:0]     model_limit;
	logic signed [OCT_W-1:0] model_octave;

	alloc_result_t pending_allocs[$];
	note_t         recent_notes[$];
	stim_row_t     directed[$];
	int            mismatch_count = 0;
	int            items_taken = 0;
	int            cycle_count = 0;
	int            burst_left = 1;

	// ------------------------------------------------------------------
	// Predictor: one note event in, one allocation result out
	// ------------------------------------------------------------------
	function automatic alloc_result_t allocate_voice(note_event_t ev);
		alloc_result_t r;
		int lim;
		int vel;
		int oct;
		int chosen;
		bit found;
		logic [7:0] pitch;
		r = '0;
		lim = int'(model_limit);
		if (lim == 0) lim = 1;
		if (lim > MAX_VOICES) lim = MAX_VOICES;
		vel = int'(ev.velocity);
		if (vel < 0) vel = 0;
		if (vel > 1024) vel = 1024;

		if (ev.func == NOTE_OFF || vel == 0) begin
			// release every voice in range holding this note
			for (int i = 0; i < lim; i++) begin
				if (held_notes[i] == {1'b0, ev.note}) begin
					if (gate_state[i]) r.stopped[i] = 1'b1;
					gate_state[i] = 1'b0;
				end
			end
		end else begin
			oct = int'(model_octave);
			if (oct < -3) oct = -3;
			chosen = 0;
			found = 1'b0;
			// highest free voice wins
			for (int i = 0; i < lim; i++) begin
				if (!gate_state[i]) begin
					chosen = i;
					found = 1'b1;
				end
			end
			// all busy: round-robin steal, stale pointer falls back to voice 0
			if (!found) begin
				chosen = (steal_ptr < lim) ? steal_ptr : 0;
				steal_ptr = (chosen + 1) % lim;
			end
			if (gate_state[chosen]) begin
				gate_state[chosen] = 1'b0;
				r.stopped[chosen] = 1'b1;
			end
			held_notes[chosen] = {1'b0, ev.note};
			pitch = 8'(int'(ev.note) + oct * 12);
			if (pitch < 8'd128) begin
				gate_state[chosen] = 1'b1;
				r.started = 1'b1;
				r.voice = voice_idx_t'(chosen);
				r.pitch = pitch[NOTE_W-1:0];
				r.velocity = CVEL_W'(vel);
			end
		end
		r.gates = gate_state;
		return r;
	endfunction

	// directed table rows
	function automatic stim_row_t ev_row(note_func_e f, int note, int vel);
		stim_row_t row;
		row = '{kind: ROW_EVENT, ev: '0, cfg_idx: '0, cfg_val: '0, typed: 1'b0, want: '0};
		row.ev.func = f;
		row.ev.note = note_t'(note);
		row.ev.velocity = VEL_W'(vel);
		return row;
	endfunction

	function automatic stim_row_t chk_row(note_func_e f, int note, int vel, bit st,
		int voice, int pitch, int svel, int stopped, int gates);
		stim_row_t row;
		row = ev_row(f, note, vel);
		row.typed = 1'b1;
		row.want.started = st;
		row.want.voice = voice_idx_t'(voice);
		row.want.pitch = note_t'(pitch);
		row.want.velocity = CVEL_W'(svel);
		row.want.stopped = voice_mask_t'(stopped);
		row.want.gates = voice_mask_t'(gates);
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t row;
		row = '{kind: ROW_CFG, ev: '0, cfg_idx: idx, cfg_val: CFG_W'(val), typed: 1'b0,
			want: '0};
		return row;
	endfunction

	// random traffic: mostly note-on/off pairs over a small pool of live notes
	function automatic note_event_t random_event();
		note_event_t ev;
		int pick;
		ev.func = ($urandom_range(0, 99) < 35) ? NOTE_OFF : NOTE_ON;
		pick = (ev.func == NOTE_OFF) ? 85 : 30;
		if (recent_notes.size() > 0 && $urandom_range(0, 99) < pick)
			ev.note = recent_notes[$urandom_range(0, recent_notes.size() - 1)];
		else
			ev.note = note_t'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			ev.velocity = VEL_W'($urandom_range(1, 1024));
		else if (pick < 78)
			ev.velocity = '0;
		else if (pick < 86)
			ev.velocity = VEL_W'($urandom_range(1025, 2047));
		else
			ev.velocity = VEL_W'($urandom);
		if (ev.func == NOTE_ON) begin
			recent_notes.push_back(ev.note);
			if (recent_notes.size() > 12) void'(recent_notes.pop_front());
		end
		return ev;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// sender pacing: random bursts with random gaps between them
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// offer one note event, wait for the transaction, queue its expected result
	task automatic send_event(note_event_t ev, bit typed, alloc_result_t want);
		alloc_result_t predicted;
		in_ch.valid <= 1'b1;
		in_ch.func <= ev.func;
		in_ch.note <= ev.note;
		in_ch.velocity <= ev.velocity;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predicted = allocate_voice(ev);
		pending_allocs.push_back(typed ? want : predicted);
		items_taken++;
		pace_sender();
	endtask

	// wait until every result is out and the sequencer has gone quiet
	task automatic drain_block();
		in_ch.valid <= 1'b0;
		while (pending_allocs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VOICE_LIMIT)
			model_limit = val;
		else
			model_octave = val[OCT_W-1:0];
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		in_ch.valid <= 1'b0;
		in_ch.func <= 1'b0;
		in_ch.note <= '0;
		in_ch.velocity <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		gate_state = '0;
		foreach (held_notes[i]) held_notes[i] = '0;
		steal_ptr = 0;
		model_limit = LIMIT_RESET;
		model_octave = '0;

		directed = '{
			// reset settings: highest free voice first, velocity clamps
			chk_row(NOTE_ON, 60, 1024, 1, 7, 60, 1024, 'h00, 'h80),
			chk_row(NOTE_ON, 0, 2047, 1, 6, 0, 1024, 'h00, 'hC0),
			chk_row(NOTE_ON, 127, -2048, 0, 0, 0, 0, 'h00, 'hC0),
			chk_row(NOTE_OFF, 0, 'h555, 0, 0, 0, 0, 'h40, 'h80),
			chk_row(NOTE_ON, 127, 1, 1, 6, 127, 1, 'h00, 'hC0),
			// two voices, then round-robin steals
			cfg_row(CFG_VOICE_LIMIT, 2),
			chk_row(NOTE_ON, 10, 500, 1, 1, 10, 500, 'h00, 'hC2),
			chk_row(NOTE_ON, 11, 600, 1, 0, 11, 600, 'h00, 'hC3),
			chk_row(NOTE_ON, 12, 700, 1, 0, 12, 700, 'h01, 'hC3),
			chk_row(NOTE_ON, 13, 800, 1, 1, 13, 800, 'h02, 'hC3),
			// shift of -4 saturates; stolen voice lands below pitch 0
			cfg_row(CFG_OCTAVE_SHIFT, 4),
			cfg_row(CFG_VOICE_LIMIT, 1),
			chk_row(NOTE_ON, 13, 1024, 0, 0, 0, 0, 'h01, 'hC2),
			chk_row(NOTE_OFF, 13, -1, 0, 0, 0, 0, 'h00, 'hC2),
			// limit of zero acts as one; pitch above 127 stays silent
			cfg_row(CFG_VOICE_LIMIT, 0),
			cfg_row(CFG_OCTAVE_SHIFT, 3),
			chk_row(NOTE_ON, 100, 300, 0, 0, 0, 0, 'h00, 'hC2),
			chk_row(NOTE_ON, 91, 300, 1, 0, 127, 300, 'h00, 'hC3),
			// oversized limit saturates to all voices
			cfg_row(CFG_VOICE_LIMIT, 15),
			cfg_row(CFG_OCTAVE_SHIFT, 7),
			chk_row(NOTE_ON, 12, 1024, 1, 5, 0, 1024, 'h00, 'hE3),
			chk_row(NOTE_ON, 5, 1024, 0, 0, 0, 0, 'h00, 'hE3),
			ev_row(NOTE_ON, 64, 64),
			ev_row(NOTE_ON, 65, 1023),
			ev_row(NOTE_ON, 66, 512),
			ev_row(NOTE_ON, 70, 1024),
			ev_row(NOTE_ON, 71, 100),
			ev_row(NOTE_ON, 72, 200),
			// pointer left past the new limit; voices above the limit stay put
			cfg_row(CFG_VOICE_LIMIT, 2),
			ev_row(NOTE_ON, 80, 1025),
			ev_row(NOTE_OFF, 72, 0),
			ev_row(NOTE_ON, 0, -1)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			if (directed[r].kind == ROW_CFG) begin
				drain_block();
				write_reg(directed[r].cfg_idx, directed[r].cfg_val);
			end else begin
				send_event(directed[r].ev, directed[r].typed, directed[r].want);
			end
		end

		// random phases sweep every limit code and every shift code
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_block();
			write_reg(CFG_VOICE_LIMIT, CFG_W'((ph * 5) % 16));
			write_reg(CFG_OCTAVE_SHIFT, {1'($urandom_range(0, 1)), 3'((ph * 3) % 8)});
			for (int n = 0; n < PHASE_EVENTS; n++)
				send_event(random_event(), 1'b0, '0);
		end

		drain_block();
		if (mismatch_count == 0)
			$display("poly_voice_allocator_top_tb: PASS");
		else
			$display("poly_voice_allocator_top_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern of its own plus one long hold
	// ------------------------------------------------------------------
	initial begin
		int mode;
		int seg;
		bit held_once;
		held_once = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_once && items_taken >= HOLD_AFTER) begin
				held_once = 1'b1;
				out_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			seg = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
			for (int k = 0; k < seg; k++) begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: out_ch.ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: in-order compare against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.started = out_ch.started;
			got.voice = out_ch.started_voice;
			got.pitch = out_ch.started_pitch;
			got.velocity = out_ch.started_velocity;
			got.stopped = out_ch.stopped_mask;
			got.gates = out_ch.gates_now;
			if (pending_allocs.size() == 0) begin
				report_mismatch("unexpected result (gates_now)", got.gates, 0);
			end else begin
				want = pending_allocs.pop_front();
				if (got.started !== want.started)
					report_mismatch("started", got.started, want.started);
				if (got.voice !== want.voice)
					report_mismatch("started_voice", got.voice, want.voice);
				if (got.pitch !== want.pitch)
					report_mismatch("started_pitch", got.pitch, want.pitch);
				if (got.velocity !== want.velocity)
					report_mismatch("started_velocity", got.velocity, want.velocity);
				if (got.stopped !== want.stopped)
					report_mismatch("stopped_mask", got.stopped, want.stopped);
				if (got.gates !== want.gates)
					report_mismatch("gates_now", got.gates, want.gates);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("poly_voice_allocator_top_tb: FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
